// ----- rtl/core/fixed_point_matrix_rotate_unit_assert.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the matrix rotate unit
// Clocked, reset-qualified property wrappers used by the port checker.
// ----------------------------------------------------------------------------
`ifndef FIXED_POINT_MATRIX_ROTATE_UNIT_ASSERT_SVH
`define FIXED_POINT_MATRIX_ROTATE_UNIT_ASSERT_SVH

// consequent must hold in the same cycle as the antecedent
`define FPMR_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// consequent must hold in the cycle after the antecedent
`define FPMR_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/core/fpmr_pkg.sv -----
// ----------------------------------------------------------------------------
// fpmr_pkg
// Shared codes, memory word locations and interface types of the matrix
// rotate unit.
// ----------------------------------------------------------------------------
package fpmr_pkg;

    // item operations
    localparam logic [1:0] OP_WRITE = 2'd0;
    localparam logic [1:0] OP_READ  = 2'd1;
    localparam logic [1:0] OP_RUN   = 2'd2;

    // result status
    localparam logic [1:0] ST_DONE  = 2'd0;
    localparam logic [1:0] ST_NOOP  = 2'd1;
    localparam logic [1:0] ST_UNSUP = 2'd2;

    // commands held in word 0
    localparam logic [15:0] CMD_NOOP   = 16'h8600;
    localparam logic [15:0] CMD_ROLL   = 16'h8800;
    localparam logic [15:0] CMD_YAW    = 16'h9000;
    localparam logic [15:0] CMD_PITCH  = 16'hA000;
    localparam logic [15:0] CMD_CAMERA = 16'hC000;

    // fixed word locations
    localparam logic [15:0] WORD_CMD   = 16'd0;
    localparam logic [15:0] WORD_BASE  = 16'd6;
    localparam logic [15:0] WORD_SIN   = 16'd7;
    localparam logic [15:0] WORD_COS   = 16'd8;
    localparam logic [15:0] WORD_CAM_A = 16'(16'hF6 / 2);
    localparam logic [15:0] WORD_CAM_B = 16'(16'hF8 / 2);
    localparam logic [15:0] WORD_CAM_C = 16'(16'hFA / 2);

    localparam int FRAC_BITS = 14;

    // one multiply-accumulate request
    typedef struct packed {
        logic               valid;
        logic               clear;  // start a new sum
        logic               neg;    // subtract the product
        logic signed [15:0] a;
        logic signed [15:0] b;
    } t_mac_req;

    // sequencer status toward the handshake logic
    typedef struct packed {
        logic        busy;
        logic        done;
        logic [15:0] read_data;
        logic [1:0]  status;
    } t_core_res;

endpackage

// ----- rtl/core/fpmr_mac.sv -----
// ----------------------------------------------------------------------------
// fpmr_mac
// Shared signed 16x16 multiplier with a registered product and an exact
// 33-bit accumulator; the result is bits 14 to 29 of the running sum.
// ----------------------------------------------------------------------------
module fpmr_mac
    import fpmr_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_mac_req    i_req,
    output logic [15:0] o_result
);

    logic signed [31:0] r_prod;
    logic               r_p_valid;
    logic               r_p_clear;
    logic               r_p_neg;
    logic signed [32:0] r_acc;
    logic signed [32:0] w_prod_ext;
    logic signed [32:0] n_acc;

    // control of the product stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p_valid <= 1'b0;
        end else begin
            r_p_valid <= i_req.valid;
        end
    end

    // product stage
    always_ff @(posedge i_clk) begin
        r_prod    <= i_req.a * i_req.b;
        r_p_clear <= i_req.clear;
        r_p_neg   <= i_req.neg;
    end

    // accumulate stage
    assign w_prod_ext = {r_prod[31], r_prod};

    always_comb begin
        n_acc = r_acc;
        if (r_p_valid) begin
            n_acc = (r_p_clear ? 33'sd0 : r_acc) + (r_p_neg ? -w_prod_ext : w_prod_ext);
        end
    end

    always_ff @(posedge i_clk) begin
        r_acc <= n_acc;
    end

    assign o_result = r_acc[FRAC_BITS+15:FRAC_BITS];

endmodule

// ----- rtl/core/fpmr_core.sv -----
// ----------------------------------------------------------------------------
// fpmr_core
// Word memory and the sequencer that runs items through its single port:
// word reads and writes, rotations and the camera product.
// ----------------------------------------------------------------------------
module fpmr_core
    import fpmr_pkg::*;
#(
    parameter int MEM_DEPTH = 4096
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [1:0]  i_operation,
    input  logic [11:0] i_address,
    input  logic [15:0] i_write_data,
    input  logic        i_res_free,
    input  logic [15:0] i_mac_result,
    output t_mac_req    o_mac_req,
    output t_core_res   o_res
);

    localparam int AW = $clog2(MEM_DEPTH);

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_RDW   = 4'd1;
    localparam logic [3:0] S_CMD   = 4'd2;
    localparam logic [3:0] S_RBASE = 4'd3;
    localparam logic [3:0] S_RSIN  = 4'd4;
    localparam logic [3:0] S_RCOS  = 4'd5;
    localparam logic [3:0] S_RLD   = 4'd6;
    localparam logic [3:0] S_RMAC  = 4'd7;
    localparam logic [3:0] S_CBA   = 4'd8;
    localparam logic [3:0] S_CBB   = 4'd9;
    localparam logic [3:0] S_CBC   = 4'd10;
    localparam logic [3:0] S_CMAC  = 4'd11;
    localparam logic [3:0] S_FIN   = 4'd12;

    logic [15:0]        mem [0:MEM_DEPTH-1];
    logic [15:0]        r_rdata;

    logic [3:0]         r_state, n_state;
    logic [15:0]        r_base, n_base;     // rotation base, camera C base
    logic [15:0]        r_ba, n_ba;
    logic [15:0]        r_bb, n_bb;
    logic signed [15:0] r_sin, n_sin;
    logic signed [15:0] r_cos, n_cos;
    logic signed [15:0] r_v [0:5];
    logic [15:0]        r_opa, n_opa;
    logic [2:0]         r_idx, n_idx;       // element (rotation) or k (camera)
    logic [1:0]         r_i, n_i;
    logic [1:0]         r_j, n_j;
    logic [2:0]         r_ph, n_ph;
    logic [1:0]         r_pc, n_pc;
    logic [1:0]         r_qc, n_qc;
    logic               r_pminus, n_pminus;
    logic [15:0]        r_res_rd, n_res_rd;
    logic [1:0]         r_res_st, n_res_st;

    logic               mem_we;
    logic [AW-1:0]      mem_addr;
    logic [15:0]        mem_wdata;
    logic               v_we;
    logic [2:0]         w_eidx;
    logic [2:0]         w_idx_inc;
    logic [1:0]         w_k;
    logic [AW-1:0]      w_in_addr;
    logic [16:0]        w_in_ext;

    // base plus small offset, wrapped at the memory depth
    function automatic logic [AW-1:0] addr_of(input logic [15:0] base, input logic [3:0] off);
        logic [16:0] sum;
        sum = {1'b0, base} + {13'd0, off};
        return sum[AW-1:0];
    endfunction

    // row * 3 + column
    function automatic logic [3:0] off3(input logic [1:0] row, input logic [1:0] col);
        return {1'b0, row, 1'b0} + {2'b00, row} + {2'b00, col};
    endfunction

    // rotation element: two per row, column p then column q
    function automatic logic [3:0] rot_off(input logic [2:0] e, input logic [1:0] pc,
                                           input logic [1:0] qc);
        return off3(e[2:1], e[0] ? qc : pc);
    endfunction

    assign w_in_ext  = {5'd0, i_address};
    assign w_in_addr = w_in_ext[AW-1:0];
    assign w_idx_inc = 3'(r_idx + 3'd1);
    assign w_eidx    = (r_state == S_RCOS) ? 3'd0 : ((r_state == S_RLD) ? w_idx_inc : r_idx);
    assign w_k       = (r_ph == 3'd2) ? w_idx_inc[1:0] : r_idx[1:0];

    // sequencer
    always_comb begin
        n_state   = r_state;
        n_base    = r_base;
        n_ba      = r_ba;
        n_bb      = r_bb;
        n_sin     = r_sin;
        n_cos     = r_cos;
        n_opa     = r_opa;
        n_idx     = r_idx;
        n_i       = r_i;
        n_j       = r_j;
        n_ph      = r_ph;
        n_pc      = r_pc;
        n_qc      = r_qc;
        n_pminus  = r_pminus;
        n_res_rd  = r_res_rd;
        n_res_st  = r_res_st;
        mem_we    = 1'b0;
        mem_addr  = addr_of(WORD_CMD, 4'd0);
        mem_wdata = i_mac_result;
        v_we      = 1'b0;
        o_mac_req = '0;

        case (r_state)
            S_IDLE: begin
                n_idx    = 3'd0;
                n_ph     = 3'd0;
                n_res_rd = 16'd0;
                n_res_st = ST_DONE;
                if (i_start) begin
                    case (i_operation)
                        OP_WRITE: begin
                            mem_we    = 1'b1;
                            mem_addr  = w_in_addr;
                            mem_wdata = i_write_data;
                            n_state   = S_FIN;
                        end
                        OP_READ: begin
                            mem_addr = w_in_addr;
                            n_state  = S_RDW;
                        end
                        OP_RUN: begin
                            mem_addr = addr_of(WORD_CMD, 4'd0);
                            n_state  = S_CMD;
                        end
                        default: begin
                            n_res_st = ST_UNSUP;
                            n_state  = S_FIN;
                        end
                    endcase
                end
            end
            S_RDW: begin
                n_res_rd = r_rdata;
                n_state  = S_FIN;
            end
            S_CMD: begin
                case (r_rdata)
                    CMD_NOOP: begin
                        n_res_st = ST_NOOP;
                        n_state  = S_FIN;
                    end
                    CMD_ROLL: begin
                        n_pc     = 2'd0;
                        n_qc     = 2'd1;
                        n_pminus = 1'b1;
                        mem_addr = addr_of(WORD_BASE, 4'd0);
                        n_state  = S_RBASE;
                    end
                    CMD_YAW: begin
                        n_pc     = 2'd0;
                        n_qc     = 2'd2;
                        n_pminus = 1'b0;
                        mem_addr = addr_of(WORD_BASE, 4'd0);
                        n_state  = S_RBASE;
                    end
                    CMD_PITCH: begin
                        n_pc     = 2'd1;
                        n_qc     = 2'd2;
                        n_pminus = 1'b1;
                        mem_addr = addr_of(WORD_BASE, 4'd0);
                        n_state  = S_RBASE;
                    end
                    CMD_CAMERA: begin
                        mem_addr = addr_of(WORD_CAM_A, 4'd0);
                        n_state  = S_CBA;
                    end
                    default: begin
                        n_res_st = ST_UNSUP;
                        n_state  = S_FIN;
                    end
                endcase
            end
            // rotation: base, sine, cosine, then six elements
            S_RBASE: begin
                n_base   = r_rdata;
                mem_addr = addr_of(WORD_SIN, 4'd0);
                n_state  = S_RSIN;
            end
            S_RSIN: begin
                n_sin    = r_rdata;
                mem_addr = addr_of(WORD_COS, 4'd0);
                n_state  = S_RCOS;
            end
            S_RCOS: begin
                n_cos    = r_rdata;
                mem_addr = addr_of(r_base, rot_off(w_eidx, r_pc, r_qc));
                n_idx    = 3'd0;
                n_state  = S_RLD;
            end
            S_RLD: begin
                v_we = 1'b1;
                if (r_idx == 3'd5) begin
                    n_idx   = 3'd0;
                    n_ph    = 3'd0;
                    n_state = S_RMAC;
                end else begin
                    mem_addr = addr_of(r_base, rot_off(w_eidx, r_pc, r_qc));
                    n_idx    = w_idx_inc;
                end
            end
            // rotation: x*cos +/- y*sin per element, then write back
            S_RMAC: begin
                case (r_ph)
                    3'd0: begin
                        o_mac_req.valid = 1'b1;
                        o_mac_req.clear = 1'b1;
                        o_mac_req.a     = r_v[r_idx];
                        o_mac_req.b     = r_cos;
                        n_ph            = 3'd1;
                    end
                    3'd1: begin
                        o_mac_req.valid = 1'b1;
                        o_mac_req.neg   = r_idx[0] ? !r_pminus : r_pminus;
                        o_mac_req.a     = r_v[r_idx ^ 3'd1];
                        o_mac_req.b     = r_sin;
                        n_ph            = 3'd2;
                    end
                    3'd2: begin
                        n_ph = 3'd3;
                    end
                    default: begin
                        mem_we   = 1'b1;
                        mem_addr = addr_of(r_base, rot_off(w_eidx, r_pc, r_qc));
                        n_ph     = 3'd0;
                        if (r_idx == 3'd5) begin
                            n_state = S_FIN;
                        end else begin
                            n_idx = w_idx_inc;
                        end
                    end
                endcase
            end
            // camera: three bases
            S_CBA: begin
                n_ba     = r_rdata;
                mem_addr = addr_of(WORD_CAM_B, 4'd0);
                n_state  = S_CBB;
            end
            S_CBB: begin
                n_bb     = r_rdata;
                mem_addr = addr_of(WORD_CAM_C, 4'd0);
                n_state  = S_CBC;
            end
            S_CBC: begin
                n_base  = r_rdata;
                n_i     = 2'd0;
                n_j     = 2'd0;
                n_idx   = 3'd0;
                n_ph    = 3'd0;
                n_state = S_CMAC;
            end
            // camera: C(i,j) = sum over k of A(i,k) * B(j,k)
            S_CMAC: begin
                case (r_ph)
                    3'd0: begin
                        mem_addr = addr_of(r_ba, off3(r_i, w_k));
                        n_ph     = 3'd1;
                    end
                    3'd1: begin
                        n_opa    = r_rdata;
                        mem_addr = addr_of(r_bb, off3(r_j, w_k));
                        n_ph     = 3'd2;
                    end
                    3'd2: begin
                        o_mac_req.valid = 1'b1;
                        o_mac_req.clear = (r_idx == 3'd0);
                        o_mac_req.a     = r_opa;
                        o_mac_req.b     = r_rdata;
                        if (r_idx == 3'd2) begin
                            n_ph = 3'd3;
                        end else begin
                            mem_addr = addr_of(r_ba, off3(r_i, w_k));
                            n_idx    = w_idx_inc;
                            n_ph     = 3'd1;
                        end
                    end
                    3'd3: begin
                        n_ph = 3'd4;
                    end
                    default: begin
                        mem_we   = 1'b1;
                        mem_addr = addr_of(r_base, off3(r_i, r_j));
                        n_idx    = 3'd0;
                        n_ph     = 3'd0;
                        if (r_j == 2'd2) begin
                            n_j = 2'd0;
                            if (r_i == 2'd2) begin
                                n_state = S_FIN;
                            end else begin
                                n_i = 2'(r_i + 2'd1);
                            end
                        end else begin
                            n_j = 2'(r_j + 2'd1);
                        end
                    end
                endcase
            end
            S_FIN: begin
                if (i_res_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // word memory, one port, registered read
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[mem_addr] <= mem_wdata;
        end
        r_rdata <= mem[mem_addr];
    end

    // element registers of a rotation
    always_ff @(posedge i_clk) begin
        if (v_we) begin
            r_v[r_idx] <= r_rdata;
        end
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_idx   <= 3'd0;
            r_ph    <= 3'd0;
            r_i     <= 2'd0;
            r_j     <= 2'd0;
        end else begin
            r_state <= n_state;
            r_idx   <= n_idx;
            r_ph    <= n_ph;
            r_i     <= n_i;
            r_j     <= n_j;
        end
    end

    // operands and result
    always_ff @(posedge i_clk) begin
        r_base   <= n_base;
        r_ba     <= n_ba;
        r_bb     <= n_bb;
        r_sin    <= n_sin;
        r_cos    <= n_cos;
        r_opa    <= n_opa;
        r_pc     <= n_pc;
        r_qc     <= n_qc;
        r_pminus <= n_pminus;
        r_res_rd <= n_res_rd;
        r_res_st <= n_res_st;
    end

    assign o_res.busy      = (r_state != S_IDLE);
    assign o_res.done      = (r_state == S_FIN) && i_res_free;
    assign o_res.read_data = r_res_rd;
    assign o_res.status    = r_res_st;

endmodule

// ----- rtl/core/fixed_point_matrix_rotate_unit.sv -----
// One item at a time: a new item is taken only once the sequencer is idle again,
// and a result that cannot enter the output register keeps it busy. All memory
// traffic runs on one port.
// Results wait in an output register, so the next item is taken while one is held.
// Reset (synchronous, active low) clears the sequencer and output valid; memory holds.
// ----------------------------------------------------------------------------
// fixed_point_matrix_rotate_unit
// Math coprocessor: word reads and writes, Q14 matrix rotations in place and
// the camera product, all over one 16-bit word memory.
// ----------------------------------------------------------------------------
module fixed_point_matrix_rotate_unit
    import fpmr_pkg::*;
#(
    parameter int MEM_DEPTH = 4096  // power of two, 256 to 65536
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [1:0]  i_operation,
    input  logic [11:0] i_address,
    input  logic [15:0] i_write_data,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [15:0] o_read_data,
    output logic [1:0]  o_status
);

    t_mac_req    w_mac_req;
    t_core_res   w_res;
    logic [15:0] w_mac_result;
    logic        w_start;
    logic        w_res_free;
    logic        r_out_valid;
    logic [15:0] r_read_data;
    logic [1:0]  r_status;

    // handshake
    assign o_in_stall = w_res.busy;
    assign w_start    = i_in_valid && !w_res.busy;
    assign w_res_free = !r_out_valid || !i_out_stall;

    fpmr_core #(
        .MEM_DEPTH (MEM_DEPTH)
    ) u_core (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_start      (w_start),
        .i_operation  (i_operation),
        .i_address    (i_address),
        .i_write_data (i_write_data),
        .i_res_free   (w_res_free),
        .i_mac_result (w_mac_result),
        .o_mac_req    (w_mac_req),
        .o_res        (w_res)
    );

    fpmr_mac u_mac (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_req    (w_mac_req),
        .o_result (w_mac_result)
    );

    // output register valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_res.done) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    // output register payload
    always_ff @(posedge i_clk) begin
        if (w_res.done) begin
            r_read_data <= w_res.read_data;
            r_status    <= w_res.status;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_read_data = r_read_data;
    assign o_status    = r_status;

endmodule

// ----- rtl/core/fpmr_checker.sv -----
// ----------------------------------------------------------------------------
// fpmr_checker
// Port-level checks of the matrix rotate unit, bound to the top level.
// ----------------------------------------------------------------------------
`include "fixed_point_matrix_rotate_unit_assert.svh"

module fpmr_checker
    import fpmr_pkg::*;
(
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        o_in_stall,
    input logic [1:0]  i_operation,
    input logic [11:0] i_address,
    input logic [15:0] i_write_data,
    input logic        o_out_valid,
    input logic        i_out_stall,
    input logic [15:0] o_read_data,
    input logic [1:0]  o_status
);

    // every accepted item makes the block busy in the following cycle
    `FPMR_ASSERT_NEXT(a_busy_after_item, i_clk, i_rst_n, i_in_valid && !o_in_stall, o_in_stall, "item accepted without a busy cycle")

    // a held result stays offered
    `FPMR_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_out_valid && i_out_stall, o_out_valid, "result dropped while stalled")

    // a held result does not change
    `FPMR_ASSERT_NEXT(a_out_stable, i_clk, i_rst_n, o_out_valid && i_out_stall, $stable(o_read_data) && $stable(o_status), "result changed while stalled")

    // only completed items carry read data
    `FPMR_ASSERT_NOW(a_rdata_zero, i_clk, i_rst_n, o_out_valid && (o_status != ST_DONE), o_read_data == 16'd0, "read data on a non-done status")

endmodule

bind fixed_point_matrix_rotate_unit fpmr_checker u_fpmr_checker (.*);
